// ===== sv/nfcs_pkg.sv =====
// nfcs_pkg: types, command constants and step table for the nor flash command sequencer
// no dependencies; used by the interfaces, nfcs_step_gen and nor_flash_command_sequencer
`timescale 1ns / 1ps

package nfcs_pkg;

  localparam int BYTE_ADDR_BITS_DEF = 24;
  localparam int ADDR_BITS          = 24;
  localparam int WADDR_BITS         = 23;
  localparam int DATA_BITS          = 16;
  localparam int TOGGLE_POS         = 6;

  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [WADDR_BITS-1:0] waddr_t;
  typedef logic [DATA_BITS-1:0]  word_t;
  typedef logic [2:0]            step_t;

  typedef enum logic [2:0] {
    OP_READ_ID = 3'd0,
    OP_CFI     = 3'd1,
    OP_RESET   = 3'd2,
    OP_ERASE   = 3'd3,
    OP_PROGRAM = 3'd4,
    OP_STATUS  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    SEQ_READ_ID,
    SEQ_CFI,
    SEQ_RESET,
    SEQ_ERASE,
    SEQ_PROGRAM,
    SEQ_POLL_READ,
    SEQ_POLL_DONE
  } seq_t;

  // bus addresses and command words
  localparam waddr_t ADDR_UNLOCK1 = 23'h555;
  localparam waddr_t ADDR_UNLOCK2 = 23'h2aa;
  localparam waddr_t ADDR_CFI     = 23'h55;
  localparam waddr_t ADDR_ZERO    = 23'h0;
  localparam waddr_t ADDR_ONE     = 23'h1;
  localparam word_t  CMD_UNLOCK1  = 16'h00aa;
  localparam word_t  CMD_UNLOCK2  = 16'h0055;
  localparam word_t  CMD_AUTOSEL  = 16'h0090;
  localparam word_t  CMD_CFI      = 16'h0098;
  localparam word_t  CMD_RESET    = 16'h00f0;
  localparam word_t  CMD_ERASE    = 16'h0080;
  localparam word_t  CMD_SECTOR   = 16'h0030;
  localparam word_t  CMD_PROGRAM  = 16'h00a0;
  localparam word_t  WORD_ZERO    = 16'h0000;

  // sequence loaded into the step generator
  typedef struct packed {
    seq_t   seq;
    waddr_t waddr;
    word_t  data;
  } load_t;

  typedef struct packed {
    kind_t  kind;
    waddr_t waddr;
    word_t  data;
  } bus_cycle_t;

  function automatic step_t seq_last(input seq_t seq);
    step_t r;
    case (seq)
      SEQ_READ_ID: r = 3'd5;
      SEQ_ERASE:   r = 3'd6;
      SEQ_PROGRAM: r = 3'd4;
      default:     r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic bus_cycle_t wr(input waddr_t a, input word_t d);
    bus_cycle_t r;
    r.kind  = KIND_WRITE;
    r.waddr = a;
    r.data  = d;
    return r;
  endfunction

  function automatic bus_cycle_t rd(input kind_t k, input waddr_t a);
    bus_cycle_t r;
    r.kind  = k;
    r.waddr = a;
    r.data  = WORD_ZERO;
    return r;
  endfunction

  function automatic bus_cycle_t step_cycle(input seq_t seq, input step_t step,
                                            input waddr_t wa, input word_t dat);
    bus_cycle_t r;
    case (seq)
      SEQ_READ_ID: begin
        case (step)
          3'd0:    r = wr(ADDR_UNLOCK1, CMD_UNLOCK1);
          3'd1:    r = wr(ADDR_UNLOCK2, CMD_UNLOCK2);
          3'd2:    r = wr(ADDR_UNLOCK1, CMD_AUTOSEL);
          3'd3:    r = rd(KIND_READ, ADDR_ZERO);
          3'd4:    r = rd(KIND_READ, ADDR_ONE);
          default: r = wr(ADDR_ZERO, CMD_RESET);
        endcase
      end
      SEQ_CFI:   r = wr(ADDR_CFI, CMD_CFI);
      SEQ_RESET: r = wr(ADDR_ZERO, CMD_RESET);
      SEQ_ERASE: begin
        case (step)
          3'd0, 3'd3: r = wr(ADDR_UNLOCK1, CMD_UNLOCK1);
          3'd1, 3'd4: r = wr(ADDR_UNLOCK2, CMD_UNLOCK2);
          3'd2:       r = wr(ADDR_UNLOCK1, CMD_ERASE);
          3'd5:       r = wr(wa, CMD_SECTOR);
          default:    r = rd(KIND_READ, wa);
        endcase
      end
      SEQ_PROGRAM: begin
        case (step)
          3'd0:    r = wr(ADDR_UNLOCK1, CMD_UNLOCK1);
          3'd1:    r = wr(ADDR_UNLOCK2, CMD_UNLOCK2);
          3'd2:    r = wr(ADDR_UNLOCK1, CMD_PROGRAM);
          3'd3:    r = wr(wa, dat);
          default: r = rd(KIND_READ, wa);
        endcase
      end
      SEQ_POLL_READ: r = rd(KIND_READ, wa);
      default:       r = rd(KIND_DONE, wa);
    endcase
    return r;
  endfunction

endpackage

// ===== sv/nfcs_if.sv =====
// nfcs_req_if and nfcs_res_if: valid/ready channels for requests and bus cycle results
// depends on nfcs_pkg for field types
`timescale 1ns / 1ps

interface nfcs_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  nfcs_pkg::addr_t   address;
  nfcs_pkg::word_t   data;

  modport source (output valid, output operation, output address, output data, input ready);
  modport sink   (input valid, input operation, input address, input data, output ready);
endinterface

interface nfcs_res_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cycle_kind;
  nfcs_pkg::waddr_t  word_address;
  nfcs_pkg::word_t   bus_data;
  logic              last;

  modport source (output valid, output cycle_kind, output word_address, output bus_data,
                  output last, input ready);
  modport sink   (input valid, input cycle_kind, input word_address, input bus_data,
                  input last, output ready);
endinterface

// ===== sv/nfcs_step_gen.sv =====
// nfcs_step_gen: holds one loaded command sequence and plays it out one bus cycle per item
// depends on nfcs_pkg and nfcs_res_if
`timescale 1ns / 1ps

module nfcs_step_gen (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  nfcs_pkg::load_t load_item,
  output logic            free,
  nfcs_res_if.source      res
);
  import nfcs_pkg::*;

  logic       seq_valid;
  load_t      cur;
  step_t      step;
  logic       out_open;
  logic       emit;
  logic       final_step;
  bus_cycle_t cyc;

  assign out_open   = !res.valid || res.ready;
  assign emit       = seq_valid && out_open;
  assign final_step = (step == seq_last(cur.seq));
  assign free       = !seq_valid || (emit && final_step);
  assign cyc        = step_cycle(cur.seq, step, cur.waddr, cur.data);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_valid <= 1'b0;
      step      <= '0;
    end else if (load) begin
      seq_valid <= 1'b1;
      step      <= '0;
    end else if (emit) begin
      if (final_step) begin
        seq_valid <= 1'b0;
      end
      step <= step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= load_item;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_open) begin
      res.valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.cycle_kind   <= cyc.kind;
      res.word_address <= cyc.waddr;
      res.bus_data     <= cyc.data;
      res.last         <= final_step;
    end
  end

endmodule

// ===== sv/nor_flash_command_sequencer.sv =====
// nor_flash_command_sequencer: request decode, erase/program busy poll, bus cycle sequencing
// depends on nfcs_pkg, nfcs_req_if, nfcs_res_if and nfcs_step_gen
`timescale 1ns / 1ps
// a request loads the sequence register; its bus cycles then pass the output register to res
// a request with n bus cycles (1 to 7) holds the sequence register until all n have left it,
//   the next request is taken in the cycle its last bus cycle enters the output register;
//   requests that give no result load nothing; while res holds off, the sequence stalls
// reset: rst clears busy, poll state, sequence valid and output valid

module nor_flash_command_sequencer #(
  parameter int BYTE_ADDR_BITS = nfcs_pkg::BYTE_ADDR_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  nfcs_req_if.sink   req,
  nfcs_res_if.source res
);
  import nfcs_pkg::*;

  localparam logic [32:0] AddrMaskWide = (33'd1 << BYTE_ADDR_BITS) - 33'd1;
  localparam logic [31:0] AddrMask     = AddrMaskWide[31:0];

  logic   busy;
  logic   have_sample;
  logic   previous_toggle;
  waddr_t poll_word_address;

  logic   busy_next;
  logic   have_sample_next;
  logic   previous_toggle_next;
  waddr_t poll_word_address_next;

  logic        free;
  logic        accept;
  logic        load;
  load_t       load_item;
  logic [31:0] addr_masked;
  waddr_t      wa_in;
  logic        toggle_in;

  assign addr_masked = 32'(req.address) & AddrMask;
  assign wa_in       = addr_masked[WADDR_BITS:1];
  assign toggle_in   = req.data[TOGGLE_POS];
  assign req.ready   = free;
  assign accept      = req.valid && req.ready;

  always_comb begin
    busy_next              = busy;
    have_sample_next       = have_sample;
    previous_toggle_next   = previous_toggle;
    poll_word_address_next = poll_word_address;
    load                   = 1'b0;
    load_item.seq          = SEQ_RESET;
    load_item.waddr        = wa_in;
    load_item.data         = req.data;
    if (accept) begin
      case (op_t'(req.operation))
        OP_STATUS: begin
          if (busy) begin
            load            = 1'b1;
            load_item.waddr = poll_word_address;
            if (have_sample && toggle_in == previous_toggle) begin
              load_item.seq    = SEQ_POLL_DONE;
              busy_next        = 1'b0;
              have_sample_next = 1'b0;
            end else begin
              load_item.seq        = SEQ_POLL_READ;
              have_sample_next     = 1'b1;
              previous_toggle_next = toggle_in;
            end
          end
        end
        OP_READ_ID: begin
          load          = !busy;
          load_item.seq = SEQ_READ_ID;
        end
        OP_CFI: begin
          load          = !busy;
          load_item.seq = SEQ_CFI;
        end
        OP_RESET: begin
          load          = !busy;
          load_item.seq = SEQ_RESET;
        end
        OP_ERASE, OP_PROGRAM: begin
          load_item.seq = (op_t'(req.operation) == OP_ERASE) ? SEQ_ERASE : SEQ_PROGRAM;
          if (!busy) begin
            load                   = 1'b1;
            busy_next              = 1'b1;
            have_sample_next       = 1'b0;
            poll_word_address_next = wa_in;
          end
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy              <= 1'b0;
      have_sample       <= 1'b0;
      previous_toggle   <= 1'b0;
      poll_word_address <= '0;
    end else begin
      busy              <= busy_next;
      have_sample       <= have_sample_next;
      previous_toggle   <= previous_toggle_next;
      poll_word_address <= poll_word_address_next;
    end
  end

  nfcs_step_gen u_step_gen (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .load_item (load_item),
    .free      (free),
    .res       (res)
  );

  // a done result always closes its item
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.cycle_kind == KIND_DONE |-> res.last)
    else $error("done result without last");

  // only write cycles carry data
  a_read_data_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.cycle_kind != KIND_WRITE |-> res.bus_data == WORD_ZERO)
    else $error("non-write cycle with nonzero data");

  // erase or program taken while idle starts the poll
  a_enter_busy: assert property (@(posedge clk) disable iff (rst)
    accept && !busy && (req.operation == OP_ERASE || req.operation == OP_PROGRAM)
    |=> busy && !have_sample)
    else $error("busy poll not entered");

  // a status word while idle changes nothing
  a_idle_status: assert property (@(posedge clk) disable iff (rst)
    accept && !busy && req.operation == OP_STATUS |=> !busy)
    else $error("status word while idle left busy set");

endmodule

// ===== test/nor_flash_command_sequencer_test.sv =====
// nor_flash_command_sequencer_test: self-checking bench for the nor flash command sequencer
// predicts the bus cycles of every accepted request and checks them in order on res
// depends on nfcs_pkg, nfcs_req_if, nfcs_res_if and nor_flash_command_sequencer
`timescale 1ns / 1ps

module nor_flash_command_sequencer_test;
  import nfcs_pkg::*;

  localparam int ITEM_TARGET   = 470;
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_CYCLES    = 7;

  localparam logic [2:0] OP_UNDEF_LO = 3'd6;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;

  typedef struct packed {
    kind_t  kind;
    waddr_t waddr;
    word_t  data;
    logic   last;
  } flash_cycle_t;

  logic clk = 1'b0;
  logic rst;

  nfcs_req_if req();
  nfcs_res_if res();

  nor_flash_command_sequencer dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted flash controller state
  logic   flash_busy;
  logic   poll_have_sample;
  logic   poll_toggle;
  waddr_t poll_waddr;

  flash_cycle_t expected_cycles[$];
  flash_cycle_t staged[MAX_CYCLES];
  int           staged_count;

  int error_count;
  int productive_items;
  int burst_left;
  bit hold_off_request;

  task automatic report_error(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic void stage_cycle(input kind_t k, input waddr_t a, input word_t d);
    staged[staged_count].kind  = k;
    staged[staged_count].waddr = a;
    staged[staged_count].data  = d;
    staged[staged_count].last  = 1'b0;
    staged_count++;
  endfunction

  function automatic void stage_unlock();
    stage_cycle(KIND_WRITE, ADDR_UNLOCK1, CMD_UNLOCK1);
    stage_cycle(KIND_WRITE, ADDR_UNLOCK2, CMD_UNLOCK2);
  endfunction

  // works out the bus cycles one accepted item causes and queues them
  function automatic void predict_bus_cycles(input logic [2:0] op, input addr_t addr,
                                             input word_t dat);
    waddr_t       wa;
    logic         toggle;
    flash_cycle_t c;
    wa = waddr_t'(addr[ADDR_BITS-1:1]);
    staged_count = 0;
    if (op == OP_STATUS) begin
      if (flash_busy) begin
        toggle = dat[TOGGLE_POS];
        if (poll_have_sample && toggle == poll_toggle) begin
          stage_cycle(KIND_DONE, poll_waddr, WORD_ZERO);
          flash_busy       = 1'b0;
          poll_have_sample = 1'b0;
        end else begin
          poll_have_sample = 1'b1;
          poll_toggle      = toggle;
          stage_cycle(KIND_READ, poll_waddr, WORD_ZERO);
        end
      end
    end else if (!flash_busy) begin
      case (op)
        OP_READ_ID: begin
          stage_unlock();
          stage_cycle(KIND_WRITE, ADDR_UNLOCK1, CMD_AUTOSEL);
          stage_cycle(KIND_READ, ADDR_ZERO, WORD_ZERO);
          stage_cycle(KIND_READ, ADDR_ONE, WORD_ZERO);
          stage_cycle(KIND_WRITE, ADDR_ZERO, CMD_RESET);
        end
        OP_CFI:   stage_cycle(KIND_WRITE, ADDR_CFI, CMD_CFI);
        OP_RESET: stage_cycle(KIND_WRITE, ADDR_ZERO, CMD_RESET);
        OP_ERASE: begin
          stage_unlock();
          stage_cycle(KIND_WRITE, ADDR_UNLOCK1, CMD_ERASE);
          stage_unlock();
          stage_cycle(KIND_WRITE, wa, CMD_SECTOR);
          stage_cycle(KIND_READ, wa, WORD_ZERO);
        end
        OP_PROGRAM: begin
          stage_unlock();
          stage_cycle(KIND_WRITE, ADDR_UNLOCK1, CMD_PROGRAM);
          stage_cycle(KIND_WRITE, wa, dat);
          stage_cycle(KIND_READ, wa, WORD_ZERO);
        end
        default: ;
      endcase
      if (op == OP_ERASE || op == OP_PROGRAM) begin
        flash_busy       = 1'b1;
        poll_have_sample = 1'b0;
        poll_waddr       = wa;
      end
    end
    for (int i = 0; i < staged_count; i++) begin
      c = staged[i];
      c.last = (i == staged_count - 1);
      expected_cycles.push_back(c);
    end
    if (staged_count > 0) productive_items++;
  endfunction

  // offers one item in bursts with random gaps, returns once it is accepted
  task automatic send_item(input logic [2:0] op, input addr_t addr, input word_t dat);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req.valid     <= 1'b1;
    req.operation <= op;
    req.address   <= addr;
    req.data      <= dat;
    do @(posedge clk); while (req.ready !== 1'b1);
    predict_bus_cycles(op, addr, dat);
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    req.valid <= 1'b0;
    while (expected_cycles.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    flash_cycle_t want;
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1) begin
      if (expected_cycles.size() == 0) begin
        report_error($sformatf("unexpected result kind %0d addr 0x%0h data 0x%0h last %0b",
                               res.cycle_kind, res.word_address, res.bus_data, res.last));
      end else begin
        want = expected_cycles.pop_front();
        if (res.cycle_kind !== want.kind)
          report_error($sformatf("cycle_kind got %0d expected %0d",
                                 res.cycle_kind, want.kind));
        if (res.word_address !== want.waddr)
          report_error($sformatf("word_address got 0x%0h expected 0x%0h",
                                 res.word_address, want.waddr));
        if (res.bus_data !== want.data)
          report_error($sformatf("bus_data got 0x%0h expected 0x%0h",
                                 res.bus_data, want.data));
        if (res.last !== want.last)
          report_error($sformatf("last got %0b expected %0b", res.last, want.last));
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int stretch;
    int mode;
    int phase;
    int hold_left;
    stretch   = 0;
    mode      = 0;
    phase     = 0;
    hold_left = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
        if (hold_left == 0) hold_off_request = 1'b0;
      end else if (hold_off_request) begin
        hold_left = HOLD_CYCLES;
        res.ready <= 1'b0;
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(0, 3);
          stretch = $urandom_range(10, 60);
          phase   = 0;
        end
        stretch--;
        phase++;
        case (mode)
          0:       res.ready <= 1'b1;
          1:       res.ready <= ($urandom_range(0, 3) != 0);
          2:       res.ready <= (phase % 5 < 2);
          default: res.ready <= (phase % 7 == 0);
        endcase
      end
    end
  end

  task automatic test_directed_sequences();
    send_item(OP_READ_ID, 24'h000000, 16'h0000);
    send_item(OP_CFI, 24'hffffff, 16'hffff);
    send_item(OP_RESET, 24'h123456, 16'h5a5a);
    // status and undefined codes while idle are dropped
    send_item(OP_STATUS, 24'h000000, 16'hffff);
    send_item(OP_UNDEF_LO, 24'hffffff, 16'hffff);
    send_item(OP_UNDEF_HI, 24'h000000, 16'h0000);
    send_item(OP_ERASE, 24'h000000, 16'h0000);
    // every request but status while busy is dropped
    send_item(OP_READ_ID, 24'h000000, 16'h0000);
    send_item(OP_CFI, 24'h000000, 16'h0000);
    send_item(OP_RESET, 24'h000000, 16'h0000);
    send_item(OP_ERASE, 24'h555554, 16'h0000);
    send_item(OP_PROGRAM, 24'hffffff, 16'hffff);
    send_item(OP_UNDEF_HI, 24'hffffff, 16'hffff);
    send_item(OP_STATUS, 24'h000000, 16'h0040);
    send_item(OP_STATUS, 24'hffffff, 16'h0000);
    send_item(OP_STATUS, 24'h000000, 16'hffbf);
    send_item(OP_PROGRAM, 24'hffffff, 16'hffff);
    send_item(OP_STATUS, 24'h000000, 16'hffff);
    send_item(OP_STATUS, 24'h000000, 16'h0040);
    send_item(OP_PROGRAM, 24'h000001, 16'h0000);
    send_item(OP_STATUS, 24'hffffff, 16'h0000);
    send_item(OP_STATUS, 24'hffffff, 16'hffbf);
    send_item(OP_ERASE, 24'haaaaaa, 16'hffff);
    send_item(OP_STATUS, 24'h000000, 16'hffff);
    send_item(OP_STATUS, 24'h000000, 16'hffff);
    wait_drained();
  endtask

  // receiver holds off while read ids keep coming, so the input stalls
  task automatic test_output_backpressure();
    hold_off_request = 1'b1;
    repeat (10) send_item(OP_READ_ID, addr_t'($urandom), word_t'($urandom));
    wait_drained();
  endtask

  task automatic send_poll_sequence();
    logic  toggle;
    word_t dat;
    send_item($urandom_range(0, 1) ? OP_ERASE : OP_PROGRAM, addr_t'($urandom),
              word_t'($urandom));
    toggle = $urandom_range(0, 1);
    while (flash_busy) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(3'($urandom_range(0, 7)), addr_t'($urandom), word_t'($urandom));
      end else begin
        if ($urandom_range(0, 1)) toggle = ~toggle;
        dat = word_t'($urandom);
        dat[TOGGLE_POS] = toggle;
        send_item(OP_STATUS, addr_t'($urandom), dat);
      end
    end
  endtask

  task automatic test_random_traffic();
    int  pick;
    bit  paused;
    paused = 1'b0;
    while (productive_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)
        send_poll_sequence();
      else if (pick < 8)
        send_item(3'($urandom_range(0, 2)), addr_t'($urandom), word_t'($urandom));
      else
        send_item(3'($urandom_range(0, 7)), addr_t'($urandom), word_t'($urandom));
      // sender pauses once midway until everything has come back
      if (!paused && productive_items >= ITEM_TARGET / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end
    wait_drained();
  endtask

  initial begin
    error_count      = 0;
    productive_items = 0;
    burst_left       = 0;
    hold_off_request = 1'b0;
    flash_busy       = 1'b0;
    poll_have_sample = 1'b0;
    poll_toggle      = 1'b0;
    poll_waddr       = '0;
    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.operation <= OP_RESET;
    req.address   <= '0;
    req.data      <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_sequences();
    test_output_backpressure();
    test_random_traffic();

    if (expected_cycles.size() != 0)
      report_error($sformatf("%0d expected results never arrived", expected_cycles.size()));
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
sv/nfcs_pkg.sv
sv/nfcs_if.sv
sv/nfcs_step_gen.sv
sv/nor_flash_command_sequencer.sv
test/nor_flash_command_sequencer_test.sv
